// ===== src/sppc_pkg.sv =====
// Shared types, codes and constant-divisor helpers for the servo preset
// position controller. No dependencies; used by servo_preset_position_controller_core.
`default_nettype none

package sppc_pkg;

    // Event kinds carried on the input tuser.
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_BUTTON = 2'd1;
    localparam logic [1:0] CMD_SERIAL = 2'd2;

    // Button codes.
    localparam logic [2:0] BTN_NEXT_MODE = 3'd0;
    localparam logic [2:0] BTN_SAVE_A    = 3'd1;
    localparam logic [2:0] BTN_LOAD_A    = 3'd2;
    localparam logic [2:0] BTN_SAVE_B    = 3'd3;
    localparam logic [2:0] BTN_LOAD_B    = 3'd4;

    // Operating modes.
    localparam logic [1:0] MODE_MANUAL   = 2'd0;
    localparam logic [1:0] MODE_REPLAY   = 2'd1;
    localparam logic [1:0] MODE_TERMINAL = 2'd2;

    // Configuration register indexes.
    localparam int          CFG_IDX_W     = 1;
    localparam logic [0:0]  CFG_WIDTH_MIN = 1'b0;
    localparam logic [0:0]  CFG_WIDTH_MAX = 1'b1;

    // Widths and reset values.
    localparam int          IN_DATA_W       = 24;
    localparam int          OUT_DATA_W      = 40;
    localparam logic [6:0]  WIDTH_MIN_RESET = 7'd15;
    localparam logic [6:0]  WIDTH_MAX_RESET = 7'd75;
    localparam logic [9:0]  DUTY_RESET      = 10'd47;
    localparam logic [6:0]  LINK3_RESET     = 7'd12;
    localparam logic [6:0]  LINK4_RESET     = 7'd12;  // tag bit added on output
    localparam logic [7:0]  PRESET_ERASED   = 8'hFF;
    localparam logic [10:0] DUTY_TOP        = 11'd1023;

    typedef logic [7:0] pos_t;

    // Input payload, packed so that channel sits in the lowest bits.
    typedef struct packed {
        logic [2:0] pad;
        logic [7:0] serial_byte;
        logic [2:0] button;
        logic [7:0] sample;
        logic [1:0] channel;
    } item_t;

    // floor(x / 255) for x below 2^15: x = 255*q0 + (lo + q0), one correction.
    function automatic logic [10:0] div_255(input logic [14:0] x);
        logic [6:0] q0;
        logic [8:0] r;
        q0 = x[14:8];
        r  = {1'b0, x[7:0]} + {2'b00, q0};
        return {4'b0000, q0} + ((r >= 9'd255) ? 11'd1 : 11'd0);
    endfunction

    // floor(x / 31) for x below 2^15, folding 32 = 31 + 1 three times.
    function automatic logic [10:0] div_31(input logic [14:0] x);
        logic [9:0]  q0;
        logic [10:0] r1;
        logic [5:0]  q1;
        logic [6:0]  r2;
        logic [1:0]  q2;
        logic [5:0]  r3;
        q0 = x[14:5];
        r1 = {6'd0, x[4:0]} + {1'b0, q0};
        q1 = r1[10:5];
        r2 = {2'd0, r1[4:0]} + {1'b0, q1};
        q2 = r2[6:5];
        r3 = {1'b0, r2[4:0]} + {4'd0, q2};
        return {1'b0, q0} + {5'd0, q1} + {9'd0, q2}
             + ((r3 >= 6'd31) ? 11'd1 : 11'd0);
    endfunction

endpackage

`default_nettype wire

// ===== src/servo_preset_position_controller_core.sv =====
// Top level of the servo preset position controller: input register, event
// handling and pulse width mapping, result register. Depends on sppc_pkg.
`default_nettype none

// The controller takes event items (button press, ADC sample or serial byte,
// selected by s_axis_tuser), one per clock cycle while the result stream is
// not stalled, and returns exactly one result item for each, holding the two
// ten-bit duties, the two link words for servos three and four and the mode in
// force after the event. An item goes through an input register and then a
// single stage of event handling and width mapping that writes the result
// register, so a result is offered once its item has passed both registers;
// the rate of one item per cycle without a stall is set by that one mapping
// stage (a 7 by 8 bit multiply followed by a constant divide). While a result
// waits in the output register the input register still takes one more item.
// Pulse width is width_min + floor(span*pos/255), or floor(span*pos/31) in
// terminal mode, with span forced to zero when width_max is below width_min;
// servo one and two duties saturate at 1023. In terminal mode bits 4:0 of the
// last serial byte are written to the position of the servo that its bits 6:5
// select after every event. The preset banks sit in flip-flops and come out of
// reset erased (all ones). Configuration writes are accepted in every cycle and
// must only be issued while the block is idle.
module servo_preset_position_controller_core #(
    parameter int SERVO_COUNT  = 4,
    parameter int PRESET_BANKS = 2
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Configuration write channel.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sppc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [6:0]                       cfg_data,
    // Event stream in.
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata, lowest bit up: channel[1:0], sample[9:2], button[12:10],
    // serial_byte[20:13], zero fill[23:21]
    input  wire logic [sppc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: cmd[1:0]
    input  wire logic [1:0]                       s_axis_tuser,
    // Result stream out.
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata, lowest bit up: duty_one[9:0], duty_two[19:10],
    // link_word_three[26:20], link_word_four[34:27], mode_now[36:35],
    // zero fill[39:37]
    output logic [sppc_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    // Only the two banks reachable from the buttons need storage.
    localparam int STORE_BANKS = (PRESET_BANKS < 2) ? PRESET_BANKS : 2;

    // Configuration registers.
    logic [6:0] width_min_reg;
    logic [6:0] width_max_reg;

    // Input register.
    logic                   s1_valid_reg;
    sppc_pkg::item_t        s1_item_reg;
    logic [1:0]             s1_cmd_reg;

    // Controller state.
    logic [1:0]     mode_reg, mode_next;
    sppc_pkg::pos_t pos_reg [SERVO_COUNT];
    sppc_pkg::pos_t pos_next [SERVO_COUNT];
    sppc_pkg::pos_t preset_reg [STORE_BANKS][SERVO_COUNT];
    sppc_pkg::pos_t preset_next [STORE_BANKS][SERVO_COUNT];
    logic [7:0]     serial_reg, serial_next;
    logic [9:0]     duty_reg [2];
    logic [9:0]     duty_next [2];
    logic [6:0]     link_reg [2];
    logic [6:0]     link_next [2];

    // Result register.
    logic                              m_valid_reg;
    logic [sppc_pkg::OUT_DATA_W-1:0]   m_data_reg;

    logic fire;
    logic ch_ok;
    logic do_save;
    logic do_load;
    logic bank_idx;
    sppc_pkg::pos_t pos_cur;
    logic [6:0]  span;
    logic [14:0] product;
    logic [10:0] quotient;
    logic [10:0] mapped;
    logic [9:0]  duty_sat;

    // The mapping stage runs whenever an item is held and the result register is free or drains.
    assign fire          = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || fire;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_min_reg <= sppc_pkg::WIDTH_MIN_RESET;
            width_max_reg <= sppc_pkg::WIDTH_MAX_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sppc_pkg::CFG_WIDTH_MIN: width_min_reg <= cfg_data;
                sppc_pkg::CFG_WIDTH_MAX: width_max_reg <= cfg_data;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s1_item_reg <= sppc_pkg::item_t'(s_axis_tdata);
            s1_cmd_reg  <= s_axis_tuser;
        end
    end

    // Position of the sampled channel as the mapping sees it: in manual mode
    // the new sample takes effect before it is mapped.
    always_comb
    begin
        pos_cur = '0;
        ch_ok   = int'(s1_item_reg.channel) < SERVO_COUNT;
        for (int i = 0; i < SERVO_COUNT; i++)
        begin
            if (int'(s1_item_reg.channel) == i)
            begin
                pos_cur = (mode_reg == sppc_pkg::MODE_MANUAL) ? s1_item_reg.sample
                                                               : pos_reg[i];
            end
        end
    end

    // Width mapping: one small multiply, then a constant divide.
    always_comb
    begin
        span     = (width_max_reg >= width_min_reg) ? (width_max_reg - width_min_reg) : 7'd0;
        product  = 15'({8'd0, span} * {7'd0, pos_cur});
        quotient = (mode_reg == sppc_pkg::MODE_TERMINAL) ? sppc_pkg::div_31(product)
                                                          : sppc_pkg::div_255(product);
        mapped   = {4'd0, width_min_reg} + quotient;
        duty_sat = (mapped > sppc_pkg::DUTY_TOP) ? sppc_pkg::DUTY_TOP[9:0] : mapped[9:0];
    end

    // Button decode for the preset banks.
    always_comb
    begin
        do_save  = (s1_item_reg.button == sppc_pkg::BTN_SAVE_A)
                || (s1_item_reg.button == sppc_pkg::BTN_SAVE_B);
        do_load  = (s1_item_reg.button == sppc_pkg::BTN_LOAD_A)
                || (s1_item_reg.button == sppc_pkg::BTN_LOAD_B);
        bank_idx = (s1_item_reg.button == sppc_pkg::BTN_SAVE_B)
                || (s1_item_reg.button == sppc_pkg::BTN_LOAD_B);
    end

    // Event handling, then the terminal-mode serial override.
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        preset_next = preset_reg;
        serial_next = serial_reg;
        duty_next   = duty_reg;
        link_next   = link_reg;
        if (fire)
        begin
            unique case (s1_cmd_reg)
                sppc_pkg::CMD_SAMPLE:
                begin
                    if (ch_ok)
                    begin
                        for (int i = 0; i < SERVO_COUNT; i++)
                        begin
                            if (int'(s1_item_reg.channel) == i)
                            begin
                                pos_next[i] = pos_cur;
                            end
                        end
                        unique case (s1_item_reg.channel)
                            2'd0:    duty_next[0] = duty_sat;
                            2'd1:    duty_next[1] = duty_sat;
                            2'd2:    link_next[0] = mapped[6:0];
                            default: link_next[1] = mapped[6:0];
                        endcase
                    end
                end
                sppc_pkg::CMD_BUTTON:
                begin
                    if (s1_item_reg.button == sppc_pkg::BTN_NEXT_MODE)
                    begin
                        mode_next = (mode_reg >= sppc_pkg::MODE_TERMINAL)
                                  ? sppc_pkg::MODE_MANUAL : mode_reg + 2'd1;
                    end
                    for (int b = 0; b < STORE_BANKS; b++)
                    begin
                        if (int'(bank_idx) == b)
                        begin
                            for (int i = 0; i < SERVO_COUNT; i++)
                            begin
                                if (do_save)
                                begin
                                    preset_next[b][i] = pos_reg[i];
                                end
                                if (do_load)
                                begin
                                    pos_next[i] = preset_reg[b][i];
                                end
                            end
                        end
                    end
                end
                sppc_pkg::CMD_SERIAL:
                begin
                    serial_next = s1_item_reg.serial_byte;
                end
                default:
                begin
                end
            endcase
            if (mode_next == sppc_pkg::MODE_TERMINAL)
            begin
                for (int i = 0; i < SERVO_COUNT; i++)
                begin
                    if (int'(serial_next[6:5]) == i)
                    begin
                        pos_next[i] = {3'd0, serial_next[4:0]};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= sppc_pkg::MODE_MANUAL;
            serial_reg <= '0;
            duty_reg   <= '{sppc_pkg::DUTY_RESET, sppc_pkg::DUTY_RESET};
            link_reg   <= '{sppc_pkg::LINK3_RESET, sppc_pkg::LINK4_RESET};
            for (int i = 0; i < SERVO_COUNT; i++)
            begin
                pos_reg[i] <= '0;
            end
            for (int b = 0; b < STORE_BANKS; b++)
            begin
                for (int i = 0; i < SERVO_COUNT; i++)
                begin
                    preset_reg[b][i] <= sppc_pkg::PRESET_ERASED;
                end
            end
        end
        else
        begin
            mode_reg    <= mode_next;
            serial_reg  <= serial_next;
            duty_reg    <= duty_next;
            link_reg    <= link_next;
            pos_reg     <= pos_next;
            preset_reg  <= preset_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            m_data_reg <= {3'd0, mode_next, 1'b1, link_next[1], link_next[0],
                           duty_next[1], duty_next[0]};
        end
    end

    // The mode only moves when an item is handled.
    a_mode_moves_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(mode_reg))
        else $error("mode changed without an item being handled");

    // A held item in the input register is never dropped while the result stalls.
    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && m_valid_reg && !m_axis_tready |=> s1_valid_reg)
        else $error("input item lost while the result was stalled");

    // A result leaves the output register only when it is taken.
    a_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_valid_reg) |-> $past(m_axis_tready))
        else $error("result dropped before it was taken");

    // Servo four's link word always carries its tag bit.
    a_link_four_tag: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> m_data_reg[34])
        else $error("servo four link word lost its tag bit");

endmodule

`default_nettype wire
